### rtl/core/a3hp_pkg.sv
`timescale 1ns / 1ps
package a3hp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int ANGLE_WIDTH_DEF  = 16;

    localparam int NCH      = 7;
    localparam int CH_W     = 3;
    localparam int WGT_W    = 32;            // Q2.30 weights
    localparam int OPND_W   = 33;            // shared multiplier operand width
    localparam int PROD_W   = 2 * OPND_W;
    localparam int CORDIC_W = 34;
    localparam int TURN_W   = 32;
    localparam int RECIP_W  = 17;

    localparam int CORDIC_ITERS = 24;
    localparam int CNT_W        = $clog2(CORDIC_ITERS);
    localparam int MUL_LAT      = 2;         // operand register + product register

    localparam int Q30_SHIFT  = 30;
    localparam int RECIP_FRAC = 16;
    localparam int WGT_DROP   = 14;          // Q2.30 -> Q2.16
    localparam int MAC_SHIFT  = 16;

    // channel slots
    localparam int IDX_W = 0;
    localparam int IDX_X = 1;
    localparam int IDX_Y = 2;
    localparam int IDX_U = 3;
    localparam int IDX_V = 4;
    localparam int IDX_P = 5;
    localparam int IDX_Q = 6;

    localparam logic [RECIP_W-1:0]      RECIP_RESET = 17'd1024;
    localparam logic signed [WGT_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [WGT_W-1:0] MIN3DB      = 32'sd759250125;

    // atan(2^-i) as a fraction of a turn, 2^32 = full turn
    localparam logic [WGT_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CC,      // c*c  -> x2
        OP_SS,      // s*s  -> y2, U
        OP_CS,      // c*s  -> V
        OP_PC,      // (x2-3y2)*c -> P
        OP_QS,      // (3x2-y2)*s -> Q
        OP_STEP,    // (target-current)*recip -> step
        OP_MAC      // weight*sample -> result
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_TRIG,
        ST_STEP,
        ST_ADVANCE,
        ST_MAC,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic             load_in;
        logic             cordic_step;
        logic [CNT_W-1:0] iter;
        op_t              op;
        logic [CH_W-1:0]  ch;
        logic             advance;
        logic             load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic signed [WGT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-WGT_W:0] hi_bits;
        hi_bits = v[PROD_W-1:WGT_W-1];
        if (hi_bits == '0 || hi_bits == '1)
        begin
            sat32 = v[WGT_W-1:0];
        end
        else if (v[PROD_W-1])
        begin
            sat32 = {1'b1, {(WGT_W-1){1'b0}}};
        end
        else
        begin
            sat32 = {1'b0, {(WGT_W-1){1'b1}}};
        end
    endfunction

endpackage

### rtl/core/a3hp_ctrl.sv
`timescale 1ns / 1ps
module a3hp_ctrl
    import a3hp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    input  logic       s_chunk_start,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_ITERS - 1);
    localparam logic [CNT_W-1:0] SLOT_CC     = CNT_W'(0);
    localparam logic [CNT_W-1:0] SLOT_SS     = CNT_W'(1);
    localparam logic [CNT_W-1:0] SLOT_CS     = CNT_W'(2);
    localparam logic [CNT_W-1:0] SLOT_PC     = CNT_W'(4);   // waits for y2
    localparam logic [CNT_W-1:0] SLOT_QS     = CNT_W'(5);
    localparam logic [CNT_W-1:0] TRIG_LAST   = SLOT_QS;
    localparam logic [CNT_W-1:0] CH_LAST     = CNT_W'(NCH + MUL_LAT - 1);
    localparam logic [CNT_W-1:0] CH_COUNT    = CNT_W'(NCH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_valid)
                begin
                    state_next = s_chunk_start ? ST_CORDIC : ST_ADVANCE;
                end
            end
            ST_CORDIC:
            begin
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = ST_TRIG;
                    cnt_next   = '0;
                end
            end
            ST_TRIG:
            begin
                if (cnt_reg == TRIG_LAST)
                begin
                    state_next = ST_STEP;
                    cnt_next   = '0;
                end
            end
            ST_STEP:
            begin
                if (cnt_reg == CH_LAST)
                begin
                    state_next = ST_ADVANCE;
                    cnt_next   = '0;
                end
            end
            ST_ADVANCE:
            begin
                state_next = ST_MAC;
                cnt_next   = '0;
            end
            ST_MAC:
            begin
                if (cnt_reg == CH_LAST)
                begin
                    state_next = ST_OUTPUT;
                    cnt_next   = '0;
                end
            end
            ST_OUTPUT:
            begin
                cnt_next = '0;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.iter    = cnt_reg;
        cmd.ch      = cnt_reg[CH_W-1:0];
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
            end
            ST_TRIG:
            begin
                case (cnt_reg)
                    SLOT_CC: cmd.op = OP_CC;
                    SLOT_SS: cmd.op = OP_SS;
                    SLOT_CS: cmd.op = OP_CS;
                    SLOT_PC: cmd.op = OP_PC;
                    SLOT_QS: cmd.op = OP_QS;
                    default: cmd.op = OP_NONE;
                endcase
            end
            ST_STEP:
            begin
                if (cnt_reg < CH_COUNT)
                begin
                    cmd.op = OP_STEP;
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
            end
            ST_MAC:
            begin
                if (cnt_reg < CH_COUNT)
                begin
                    cmd.op = OP_MAC;
                end
            end
            ST_OUTPUT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

### rtl/core/a3hp_dp.sv
`timescale 1ns / 1ps
module a3hp_dp
    import a3hp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         cmd,
    output dp_status_t                      status,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    input  logic [ANGLE_WIDTH-1:0]          azimuth,
    input  logic                            cfg_wr_en,
    input  logic [RECIP_W-1:0]              cfg_wr_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [NCH*SAMPLE_WIDTH-1:0]     m_tdata
);

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (MAC_SHIFT - 1);
    localparam int                       SHI_W    = PROD_W - SAMPLE_WIDTH + 1;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [RECIP_W-1:0]             recip_reg;

    // CORDIC
    logic signed [CORDIC_W-1:0] xc_reg, yc_reg, zc_reg;
    logic signed [CORDIC_W-1:0] xc_next, yc_next, zc_next;
    logic signed [CORDIC_W-1:0] xs_w, ys_w, atan_w, c_full, s_full;
    logic                       flip_reg;
    logic [TURN_W-1:0]          turn_w;
    logic                       flip_w;
    logic signed [WGT_W-1:0]    c_w, s_w;

    // weights
    logic signed [WGT_W-1:0]  tgt_reg  [NCH];
    logic signed [WGT_W-1:0]  cur_reg  [NCH];
    logic signed [WGT_W-1:0]  step_reg [NCH];
    logic signed [OPND_W-1:0] adv_sum  [NCH];
    logic signed [WGT_W-1:0]  x2_reg, y2_w;
    logic signed [OPND_W-1:0] pc_a_reg, qs_a_reg;

    // shared multiplier pipe
    logic signed [OPND_W-1:0] opa_next, opb_next, opa_reg, opb_reg, diff_w;
    logic signed [WGT_W-1:0]  cur_sel;
    op_t                      op1_reg, op2_reg;
    logic [CH_W-1:0]          ch1_reg, ch2_reg;
    logic signed [PROD_W-1:0] prod_reg, rnd_w;
    logic [SHI_W-1:0]         rnd_hi;
    logic signed [SAMPLE_WIDTH-1:0] mac_sat;

    logic signed [SAMPLE_WIDTH-1:0] res_reg  [NCH];
    logic signed [SAMPLE_WIDTH-1:0] obuf_reg [NCH];
    logic                           out_valid_reg;

    // angle folding into [-1/4, 1/4) turn
    assign turn_w = TURN_W'(azimuth) << (TURN_W - ANGLE_WIDTH);
    assign flip_w = turn_w[TURN_W-1] ^ turn_w[TURN_W-2];

    always_comb
    begin
        xs_w   = xc_reg >>> cmd.iter;
        ys_w   = yc_reg >>> cmd.iter;
        atan_w = $signed(CORDIC_W'(ATAN_TAB[cmd.iter]));
        if (!zc_reg[CORDIC_W-1])
        begin
            xc_next = xc_reg - ys_w;
            yc_next = yc_reg + xs_w;
            zc_next = zc_reg - atan_w;
        end
        else
        begin
            xc_next = xc_reg + ys_w;
            yc_next = yc_reg - xs_w;
            zc_next = zc_reg + atan_w;
        end
    end

    assign c_full = flip_reg ? -xc_reg : xc_reg;
    assign s_full = flip_reg ? -yc_reg : yc_reg;
    assign c_w    = c_full[WGT_W-1:0];
    assign s_w    = s_full[WGT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_reg <= RECIP_RESET;
        end
        else if (cfg_wr_en)
        begin
            recip_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= sample_in;
            xc_reg     <= CORDIC_W'(CORDIC_GAIN);
            yc_reg     <= '0;
            zc_reg     <= CORDIC_W'($signed({turn_w[TURN_W-1] ^ flip_w, turn_w[TURN_W-2:0]}));
            flip_reg   <= flip_w;
        end
        else if (cmd.cordic_step)
        begin
            xc_reg <= xc_next;
            yc_reg <= yc_next;
            zc_reg <= zc_next;
        end
    end

    // operand select
    always_comb
    begin
        cur_sel  = cur_reg[cmd.ch];
        diff_w   = OPND_W'(tgt_reg[cmd.ch]) - OPND_W'(cur_sel);
        opa_next = '0;
        opb_next = '0;
        case (cmd.op)
            OP_CC:
            begin
                opa_next = OPND_W'(c_w);
                opb_next = OPND_W'(c_w);
            end
            OP_SS:
            begin
                opa_next = OPND_W'(s_w);
                opb_next = OPND_W'(s_w);
            end
            OP_CS:
            begin
                opa_next = OPND_W'(c_w);
                opb_next = OPND_W'(s_w);
            end
            OP_PC:
            begin
                opa_next = pc_a_reg;
                opb_next = OPND_W'(c_w);
            end
            OP_QS:
            begin
                opa_next = qs_a_reg;
                opb_next = OPND_W'(s_w);
            end
            OP_STEP:
            begin
                opa_next = diff_w;
                opb_next = $signed(OPND_W'(recip_reg));
            end
            OP_MAC:
            begin
                opa_next = OPND_W'($signed(cur_sel[WGT_W-1:WGT_DROP]));
                opb_next = OPND_W'(sample_reg);
            end
            default:
            begin
                opa_next = '0;
                opb_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= OP_NONE;
            op2_reg <= OP_NONE;
        end
        else
        begin
            op1_reg <= cmd.op;
            op2_reg <= op1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        ch1_reg  <= cmd.ch;
        prod_reg <= opa_reg * opb_reg;
        ch2_reg  <= ch1_reg;
    end

    // rounding and saturation of the sample product
    always_comb
    begin
        rnd_w  = (prod_reg + RND_HALF) >>> MAC_SHIFT;
        rnd_hi = rnd_w[PROD_W-1:SAMPLE_WIDTH-1];
        if (rnd_hi == '0 || rnd_hi == '1)
        begin
            mac_sat = rnd_w[SAMPLE_WIDTH-1:0];
        end
        else if (rnd_w[PROD_W-1])
        begin
            mac_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            mac_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    assign y2_w = sat32(prod_reg >>> Q30_SHIFT);

    // targets and trig intermediates
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CC)
        begin
            tgt_reg[IDX_W] <= MIN3DB;
            tgt_reg[IDX_X] <= c_w;
            tgt_reg[IDX_Y] <= s_w;
        end
        case (op2_reg)
            OP_CC:
            begin
                x2_reg <= sat32(prod_reg >>> Q30_SHIFT);
            end
            OP_SS:
            begin
                tgt_reg[IDX_U] <= sat32(PROD_W'(x2_reg) - PROD_W'(y2_w));
                pc_a_reg <= OPND_W'(x2_reg) - OPND_W'(y2_w) - (OPND_W'(y2_w) <<< 1);
                qs_a_reg <= (OPND_W'(x2_reg) <<< 1) + OPND_W'(x2_reg) - OPND_W'(y2_w);
            end
            OP_CS:
            begin
                // 2cs in Q30 is cs shifted one less
                tgt_reg[IDX_V] <= sat32(prod_reg >>> (Q30_SHIFT - 1));
            end
            OP_PC:
            begin
                tgt_reg[IDX_P] <= sat32(prod_reg >>> Q30_SHIFT);
            end
            OP_QS:
            begin
                tgt_reg[IDX_Q] <= sat32(prod_reg >>> Q30_SHIFT);
            end
            OP_MAC:
            begin
                res_reg[ch2_reg] <= mac_sat;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            adv_sum[k] = OPND_W'(cur_reg[k]) + OPND_W'(step_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                cur_reg[k]  <= '0;
                step_reg[k] <= '0;
            end
        end
        else
        begin
            if (op2_reg == OP_STEP)
            begin
                step_reg[ch2_reg] <= sat32(prod_reg >>> RECIP_FRAC);
            end
            if (cmd.advance)
            begin
                for (int k = 0; k < NCH; k++)
                begin
                    cur_reg[k] <= sat32(PROD_W'(adv_sum[k]));
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                obuf_reg[k] <= res_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            m_tdata[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] = obuf_reg[k];
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

### rtl/core/ambisonic_3h_panner_ramped.sv
// A new input beat is taken only once the previous result has moved into the output
// register. A chunk-start beat also runs the 24-step CORDIC, five trig products and
// seven step products through the one shared multiplier.
// Reset (rst_n, async, active low): weights and steps cleared, ramp_reciprocal = 1024,
// no output beat pending.
`timescale 1ns / 1ps
module ambisonic_3h_panner_ramped
    import a3hp_pkg::*;
#(
    parameter int  SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int  ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((NCH * SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_in, azimuth, zero pad
    input  logic                   s_axis_tuser,   // chunk_start

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_w, out_x, out_y, out_u,
                                                   // out_v, out_p, out_q, zero pad

    input  logic                   cfg_wr_en,
    input  logic [RECIP_W-1:0]     cfg_wr_data     // ramp_reciprocal, unsigned Q1.16
);

    // Flow per beat:
    //   IDLE     take beat (sample latched, CORDIC seeded from azimuth)
    //   CORDIC   24 rotations, one per cycle (chunk start only)
    //   TRIG     x2, y2, 2xy, P, Q through the shared multiplier (chunk start only)
    //   STEP     per-channel ramp step = (target - current) * recip (chunk start only)
    //   ADVANCE  all seven weights += step, saturating
    //   MAC      weight * sample, rounded and saturated, one channel per cycle
    //   OUTPUT   move results into the output register once it is free
    // The multiplier has an operand register and a product register, so the step
    // and sample sequences each end by draining both registers before their
    // results are used.

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [NCH*SAMPLE_WIDTH-1:0] out_data;

    a3hp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_valid       (s_axis_tvalid),
        .s_chunk_start (s_axis_tuser),
        .s_ready       (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    a3hp_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_in   ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .azimuth     (s_axis_tdata[SAMPLE_WIDTH +: ANGLE_WIDTH]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_axis_tready),
        .m_tvalid    (m_axis_tvalid),
        .m_tdata     (out_data)
    );

    // pack channels, pad to whole bytes
    generate
        if (OUT_TDATA_W > NCH * SAMPLE_WIDTH)
        begin : g_pad
            assign m_axis_tdata = {{(OUT_TDATA_W - NCH * SAMPLE_WIDTH){1'b0}}, out_data};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = out_data;
        end
    endgenerate

endmodule

### rtl/core/a3hp_checker.sv
`timescale 1ns / 1ps
module a3hp_checker #(
    parameter int OUT_W = 168
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // stalled output beat holds
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // one beat in flight: input closes right after a beat is taken
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open during processing");

    // a new result frees the engine for the next beat
    a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input not open after result");

    // a result never appears the cycle after a beat is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");

endmodule

bind ambisonic_3h_panner_ramped a3hp_checker #(
    .OUT_W (OUT_TDATA_W)
) u_a3hp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
